### rtl/core/ttf_pkg.sv
// Shared types and constants of the tone timer factorizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package ttf_pkg;

	localparam int unsigned FREQ_MIN       = 200;
	localparam int unsigned FREQ_MAX       = 10000;
	localparam int unsigned FREQ_SILENT    = 1000;
	localparam int unsigned PRESCALE_LIMIT = 256;
	localparam int unsigned DIVISOR_MAX    = 65535;
	localparam int unsigned VAL_W          = 16;

	typedef struct packed {
		logic start_in;
		logic load_n;
		logic start_mod;
		logic apply_trial;
		logic finish_prime;
		logic load_out;
	} ttf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic n_small;
		logic d_sq_gt_n;
	} ttf_sts_t;

endpackage
`default_nettype wire

### rtl/core/ttf_dpath.sv
// Datapath of the tone timer factorizer: clamp, shared serial divider,
// trial factor registers and the result register. Depends on ttf_pkg.
`default_nettype none
module ttf_dpath import ttf_pkg::*; #(
	parameter int unsigned CLOCK_HZ    = 72000000,
	parameter int unsigned WAVE_POINTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] tone_hz,
	input  wire ttf_cmd_t    cmd,
	output ttf_sts_t         sts,
	output logic [7:0]       prescale,
	output logic [15:0]      period,
	output logic [15:0]      divisor,
	output logic             silent
);

	localparam int unsigned DVD_W = $clog2(CLOCK_HZ + 1);
	localparam int unsigned DEN_W = $clog2(WAVE_POINTS * FREQ_MAX + 1);
	localparam int unsigned DSR_W = (DEN_W > VAL_W) ? DEN_W : VAL_W;
	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [13:0]      freq;
	logic [DSR_W-1:0] denom;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSR_W:0]   shifted;
	logic             fits;
	logic [VAL_W-1:0] n_q;
	logic [VAL_W-1:0] d_q;
	logic [7:0]       a_q;
	logic [VAL_W-1:0] b_q;
	logic [VAL_W-1:0] div_q;
	logic             silent_q;
	logic [31:0]      d_sq;
	logic [23:0]      a_prod;
	logic [31:0]      b_prod_d;
	logic [31:0]      b_prod_n;
	logic [VAL_W-1:0] quo_sat;

	always_comb begin
		if (tone_hz == 16'd0) begin
			freq = 14'(FREQ_SILENT);
		end else if (tone_hz < 16'(FREQ_MIN)) begin
			freq = 14'(FREQ_MIN);
		end else if (tone_hz > 16'(FREQ_MAX)) begin
			freq = 14'(FREQ_MAX);
		end else begin
			freq = tone_hz[13:0];
		end
		denom = DSR_W'(WAVE_POINTS * 32'(freq));
	end

	assign shifted  = {rem_q, quo_q[DVD_W-1]};
	assign fits     = shifted >= {1'b0, dsr_q};
	assign d_sq     = d_q * d_q;
	assign a_prod   = a_q * d_q;
	assign b_prod_d = b_q * d_q;
	assign b_prod_n = b_q * n_q;
	assign quo_sat  = (quo_q > DVD_W'(DIVISOR_MAX)) ? VAL_W'(DIVISOR_MAX) : quo_q[VAL_W-1:0];

	assign sts.div_done  = cnt_q == '0;
	assign sts.n_small   = n_q < 16'd2;
	assign sts.d_sq_gt_n = d_sq > 32'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_in) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cmd.start_mod) begin
			cnt_q <= CNT_W'(VAL_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_in) begin
			rem_q    <= '0;
			dsr_q    <= denom;
			quo_q    <= DVD_W'(CLOCK_HZ);
			silent_q <= tone_hz == 16'd0;
		end else if (cmd.start_mod) begin
			rem_q <= '0;
			dsr_q <= DSR_W'(d_q);
			quo_q <= DVD_W'(n_q) << (DVD_W - VAL_W);
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DSR_W'(shifted - {1'b0, dsr_q}) : shifted[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
		if (cmd.load_n) begin
			div_q <= quo_sat;
			n_q   <= quo_sat;
			d_q   <= 16'd2;
			a_q   <= 8'd1;
			b_q   <= 16'd1;
		end else if (cmd.finish_prime) begin
			b_q <= b_prod_n[VAL_W-1:0];
		end else if (cmd.apply_trial) begin
			if (rem_q == '0) begin
				if (a_prod < 24'(PRESCALE_LIMIT)) begin
					a_q <= a_prod[7:0];
				end else begin
					b_q <= b_prod_d[VAL_W-1:0];
				end
				n_q <= quo_q[VAL_W-1:0];
			end else begin
				d_q <= (d_q == 16'd2) ? 16'd3 : d_q + 16'd2;
			end
		end
		if (cmd.load_out) begin
			prescale <= a_q;
			period   <= b_q;
			divisor  <= div_q;
			silent   <= silent_q;
		end
	end

endmodule
`default_nettype wire

### rtl/core/ttf_ctrl.sv
// Controller state machine of the tone timer factorizer: sequences the
// divider runs and trial steps and owns both handshakes. Depends on ttf_pkg.
`default_nettype none
module ttf_ctrl import ttf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire ttf_sts_t sts,
	output ttf_cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_TEST  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start_in = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.load_n = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.n_small) begin
					state_d = ST_FIN;
				end else if (sts.d_sq_gt_n) begin
					cmd.finish_prime = 1'b1;
					state_d          = ST_FIN;
				end else begin
					cmd.start_mod = 1'b1;
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				if (sts.div_done) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				cmd.apply_trial = 1'b1;
				state_d         = ST_CHECK;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/tone_timer_factorizer.sv
// Top level of the tone timer factorizer: joins the controller and the datapath.
// Depends on ttf_pkg, ttf_ctrl and ttf_dpath.
//
//   channel  direction  tdata fields (low bit up)                 tuser
//   s_axis   in         tone_hz[15:0]                             -
//   m_axis   out        prescale[7:0] period[23:8] divisor[39:24] silent
//
// A request runs W = clog2(CLOCK_HZ + 1) steps of the serial divider for the divisor,
// then T trials of V = 16 divider steps each, T the trial count (at most about 130;
// trials stop once the candidate squared exceeds the rest or the rest is below two).
// The serial divider gives one bit per cycle and is shared by both divisions.
// Reset is asynchronous and clears only control state. A new request is taken while a
// result waits; a stalled result holds the block before its result register.
`default_nettype none
module tone_timer_factorizer import ttf_pkg::*; #(
	parameter int unsigned CLOCK_HZ    = 72000000,
	parameter int unsigned WAVE_POINTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // tone_hz
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // prescale, period, divisor
	output logic [0:0]       m_tuser    // silent
);

	ttf_cmd_t    cmd;
	ttf_sts_t    sts;
	logic [7:0]  prescale;
	logic [15:0] period;
	logic [15:0] divisor;
	logic        silent;

	ttf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ttf_dpath #(
		.CLOCK_HZ    (CLOCK_HZ),
		.WAVE_POINTS (WAVE_POINTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.tone_hz  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.prescale (prescale),
		.period   (period),
		.divisor  (divisor),
		.silent   (silent)
	);

	assign m_tdata = {divisor, period, prescale};
	assign m_tuser = silent;

endmodule
`default_nettype wire

### sim/tb_tone_timer_factorizer.sv
// Self-checking testbench for the tone timer factorizer: directed table, then random requests.
// Typed table rows or a local model of clamping, division and prime splitting predict results.
// Depends on ttf_pkg and the tone_timer_factorizer top level.
`timescale 1ns / 1ps

module tb_tone_timer_factorizer;
	import ttf_pkg::*;

	localparam int unsigned TONE_CLOCK_HZ    = 72000000;
	localparam int unsigned TONE_WAVE_POINTS = 32;
	localparam int          REQ_CYCLES       = 3000;
	localparam int          HOLD_CYCLES      = 4 * REQ_CYCLES;
	localparam int          WATCHDOG_LIMIT   = 4 * (HOLD_CYCLES + REQ_CYCLES);
	localparam int          RANDOM_TONES     = 77;
	localparam int          MAX_GAP          = 17;
	localparam int          HOLD_AT_RESULT   = 30;
	localparam int          PAUSE_AT_TONE    = 70;
	localparam int          NUM_DIRECTED     = 23;

	typedef struct packed {
		logic [7:0]  prescale;
		logic [15:0] period;
		logic [15:0] divisor;
		logic        silent;
	} timer_setting_t;

	typedef struct packed {
		logic [15:0] hz;
		logic        typed;
		logic [7:0]  prescale;
		logic [15:0] period;
		logic [15:0] divisor;
		logic        silent;
	} tone_row_t;

	localparam tone_row_t TONE_TABLE [0:NUM_DIRECTED-1] = '{
		'{16'd0,      1'b1, 8'd90, 16'd25,  16'd2250,  1'b1},
		'{16'd65535,  1'b1, 8'd45, 16'd5,   16'd225,   1'b0},
		'{16'd1,      1'b1, 8'd90, 16'd125, 16'd11250, 1'b0},
		'{16'd10000,  1'b1, 8'd45, 16'd5,   16'd225,   1'b0},
		'{16'd200,    1'b1, 8'd90, 16'd125, 16'd11250, 1'b0},
		'{16'd199,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd201,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd1000,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd9999,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd10001,  1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd440,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd262,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd523,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd3520,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd7919,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd1234,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'h5555,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'hAAAA,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'h00FF,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'hFF00,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd5000,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd2500,   1'b0, 8'd0,  16'd0,   16'd0,     1'b0},
		'{16'd300,    1'b0, 8'd0,  16'd0,   16'd0,     1'b0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // prescale[7:0], period[23:8], divisor[39:24]
	logic [0:0]  m_tuser;   // silent

	timer_setting_t pending_settings [$];
	int             fail_count = 0;
	int             idle_cycles = 0;
	int             tones_sent = 0;
	int             results_taken = 0;

	tone_timer_factorizer #(
		.CLOCK_HZ    (TONE_CLOCK_HZ),
		.WAVE_POINTS (TONE_WAVE_POINTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic timer_setting_t tone_to_timer(input logic [15:0] hz);
		timer_setting_t  r;
		int unsigned     f;
		int unsigned     n;
		int unsigned     d;
		int unsigned     pre;
		int unsigned     per;
		longint unsigned denom;
		longint unsigned q;
		r.silent = (hz == 16'd0);
		f = (hz == 16'd0) ? FREQ_SILENT : int'(hz);
		if (f < FREQ_MIN) f = FREQ_MIN;
		if (f > FREQ_MAX) f = FREQ_MAX;
		denom = 64'(TONE_WAVE_POINTS) * 64'(f);
		q = (denom != 0) ? 64'(TONE_CLOCK_HZ) / denom : 64'(DIVISOR_MAX);
		if (q > 64'(DIVISOR_MAX)) q = 64'(DIVISOR_MAX);
		n = 32'(q);
		r.divisor = n[15:0];
		pre = 1;
		per = 1;
		if (n >= 2) begin
			d = 2;
			while (d < n) begin
				if (n % d == 0) begin
					if (pre * d < PRESCALE_LIMIT) pre = pre * d;
					else per = per * d;
					n = n / d;
				end else begin
					d = (d == 2) ? 3 : d + 2;
				end
			end
			per = per * d;
		end
		r.prescale = pre[7:0];
		r.period   = per[15:0];
		return r;
	endfunction

	task automatic offer_tone(input logic [15:0] hz, input int gap, input timer_setting_t want);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= hz;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_settings.push_back(want);
		tones_sent++;
	endtask

	function automatic int sender_gap(input int idx);
		return (idx >= 40 && idx < 56) ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		timer_setting_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_settings.size() == 0) begin
				$error("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_settings.pop_front();
				if (m_tdata[7:0] !== want.prescale) begin
					$error("prescale: expected %0d, actual %0d", want.prescale, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[23:8] !== want.period) begin
					$error("period: expected %0d, actual %0d", want.period, m_tdata[23:8]);
					fail_count++;
				end
				if (m_tdata[39:24] !== want.divisor) begin
					$error("divisor: expected %0d, actual %0d", want.divisor, m_tdata[39:24]);
					fail_count++;
				end
				if (m_tuser[0] !== want.silent) begin
					$error("silent: expected %0d, actual %0d", want.silent, m_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_taken == HOLD_AT_RESULT) wait_cycles = HOLD_CYCLES;
			else if (results_taken >= 45 && results_taken < 66) wait_cycles = 0;
			else wait_cycles = $urandom_range(0, MAX_GAP);
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_taken++;
		end
	end

	initial begin
		timer_setting_t want;
		logic [15:0]    hz;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			hz = TONE_TABLE[i].hz;
			if (TONE_TABLE[i].typed) begin
				want.prescale = TONE_TABLE[i].prescale;
				want.period   = TONE_TABLE[i].period;
				want.divisor  = TONE_TABLE[i].divisor;
				want.silent   = TONE_TABLE[i].silent;
			end else begin
				want = tone_to_timer(hz);
			end
			offer_tone(hz, int'($urandom_range(0, MAX_GAP)), want);
		end

		for (int i = 0; i < RANDOM_TONES; i++) begin
			case ($urandom_range(0, 9)) inside
				0:       hz = 16'd0;
				1:       hz = 16'($urandom_range(1, FREQ_MIN - 1));
				[2:3]:   hz = 16'($urandom_range(0, 65535));
				default: hz = 16'($urandom_range(FREQ_MIN, FREQ_MAX));
			endcase
			if (i == PAUSE_AT_TONE) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_settings.size() != 0) @(posedge clk);
			end
			offer_tone(hz, sender_gap(i), tone_to_timer(hz));
		end
		s_tvalid <= 1'b0;

		while (pending_settings.size() != 0) @(posedge clk);
		repeat (REQ_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_settings.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/ttf_pkg.sv
rtl/core/ttf_dpath.sv
rtl/core/ttf_ctrl.sv
rtl/core/tone_timer_factorizer.sv
sim/tb_tone_timer_factorizer.sv
